>>> rtl/core/sbt_pkg.sv
// sbt_pkg: shared types and constants for the SACK block tracker.
// Used by sbt_ctrl, sbt_dp and sack_block_tracker_core; no dependencies.
`timescale 1ns / 1ps
package sbt_pkg;

  localparam logic [1:0] OP_RECORD = 2'd0;
  localparam logic [1:0] OP_ACK    = 2'd1;
  localparam logic [1:0] OP_EMIT   = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3; // no update, status result only

  localparam int unsigned OPT_BASE = 2;

  // controller -> datapath commands
  typedef struct packed {
    logic load;      // capture input transaction
    logic do_record; // apply op 0 update
    logic do_ack;    // apply op 1 update
    logic emit_load; // load output register with status or block
    logic emit_blk;  // output carries a block (op 2)
    logic emit_adv;  // step emission cursor
  } sbt_cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic [1:0] op;
    logic       emit_done; // the block being loaded is the final one
  } sbt_sts_t;

endpackage

>>> rtl/core/sbt_ctrl.sv
// sbt_ctrl: controller state machine sequencing one transaction at a time.
// Depends on sbt_pkg.
`timescale 1ns / 1ps
module sbt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_fire,
  input  logic              out_fire,
  input  sbt_pkg::sbt_sts_t sts,
  output logic              in_ready,
  output logic              out_valid,
  output sbt_pkg::sbt_cmd_t cmd
);
  import sbt_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_EXEC, S_EMIT, S_HOLD, S_WAIT} state_t;

  state_t state_r;
  logic   out_valid_r;
  logic   last_r;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd = '0;
    unique case (state_r)
      S_IDLE: cmd.load = in_fire;
      S_EXEC: begin
        cmd.do_record = (sts.op == OP_RECORD);
        cmd.do_ack    = (sts.op == OP_ACK);
        cmd.emit_load = (sts.op != OP_EMIT);
      end
      S_EMIT: begin
        cmd.emit_load = 1'b1;
        cmd.emit_blk  = 1'b1;
        cmd.emit_adv  = 1'b1;
      end
      S_HOLD, S_WAIT: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      last_r      <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: if (in_fire) state_r <= S_EXEC;
        S_EXEC: begin
          if (sts.op == OP_EMIT) begin
            state_r <= S_EMIT;
          end else begin
            out_valid_r <= 1'b1;
            last_r      <= 1'b1;
            state_r     <= S_WAIT;
          end
        end
        S_EMIT: begin
          out_valid_r <= 1'b1;
          last_r      <= sts.emit_done;
          state_r     <= S_WAIT;
        end
        S_WAIT: begin
          if (out_fire) begin
            out_valid_r <= 1'b0;
            state_r     <= last_r ? S_IDLE : S_EMIT;
          end
        end
        S_HOLD: state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/core/sbt_dp.sv
// sbt_dp: block table, update logic and output register.
// Depends on sbt_pkg.
`timescale 1ns / 1ps
module sbt_dp #(
  parameter int unsigned BLOCKS    = 4,
  parameter int unsigned SEQ_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  sbt_pkg::sbt_cmd_t     cmd,
  input  logic [1:0]            in_opcode,
  input  logic [31:0]           in_seq,
  output sbt_pkg::sbt_sts_t     sts,
  output logic                  o_covered,
  output logic [3:0]            o_count,
  output logic [2:0]            o_recent,
  output logic [31:0]           o_highest,
  output logic [31:0]           o_left,
  output logic [31:0]           o_right,
  output logic [6:0]            o_optlen,
  output logic                  o_last
);
  import sbt_pkg::*;

  localparam int unsigned IW = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;
  localparam int unsigned CW = $clog2(BLOCKS + 1);
  typedef logic [SEQ_WIDTH-1:0] seq_t;

  seq_t          left_r  [BLOCKS];
  seq_t          right_r [BLOCKS];
  logic [CW-1:0] held_r;
  logic [IW-1:0] recent_r;
  seq_t          largest_r;
  logic [1:0]    op_r;
  seq_t          seq_r;
  logic [CW-1:0] cur_r;     // emission cursor: output ordinal
  logic [IW-1:0] first_r;

  seq_t          left_nxt  [BLOCKS];
  seq_t          right_nxt [BLOCKS];
  logic [CW-1:0] held_nxt;
  logic [IW-1:0] recent_nxt;
  seq_t          largest_nxt;
  logic          cov_nxt;

  assign sts.op = op_r;

  // record / ack update: each scan compares SEQ_WIDTH-wide values over BLOCKS (<= 8) entries
  always_comb begin
    seq_t          n, n1, nl, nr;
    logic          found, adj, ext_left, mrg;
    logic [IW-1:0] ai, mj, lo, hi;
    logic [CW-1:0] kc;
    for (int b = 0; b < BLOCKS; b++) begin
      left_nxt[b]  = left_r[b];
      right_nxt[b] = right_r[b];
    end
    held_nxt = held_r; recent_nxt = recent_r; largest_nxt = largest_r;
    cov_nxt = 1'b0;
    n = seq_r; n1 = seq_r + 1'b1;
    found = 1'b0; adj = 1'b0; ext_left = 1'b0; mrg = 1'b0;
    ai = '0; mj = '0; nl = '0; nr = '0; lo = '0; hi = '0; kc = '0;
    if (cmd.do_record) begin
      if (n > largest_r) largest_nxt = n;
      for (int b = 0; b < BLOCKS; b++)
        if (!found && CW'(b) < held_r && left_r[b] <= n && n < right_r[b]) begin
          found = 1'b1; ai = IW'(b);
        end
      if (found) begin
        cov_nxt = 1'b1; recent_nxt = ai;
      end else begin
        for (int b = 0; b < BLOCKS; b++)
          if (!adj && CW'(b) < held_r && (n1 == left_r[b] || n == right_r[b])) begin
            adj = 1'b1; ai = IW'(b); ext_left = (n1 == left_r[b]);
          end
        if (adj) begin
          if (ext_left) left_nxt[ai] = n; else right_nxt[ai] = n1;
          for (int b = 0; b < BLOCKS; b++)
            if (!mrg && CW'(b) < held_r && IW'(b) != ai &&
                (ext_left ? (right_r[b] == n) : (left_r[b] == n1))) begin
              mrg = 1'b1; mj = IW'(b);
            end
          if (mrg) begin
            nl = ext_left ? left_r[mj] : left_r[ai];
            nr = ext_left ? right_r[ai] : right_r[mj];
            lo = (ai < mj) ? ai : mj;
            hi = (ai < mj) ? mj : ai;
            left_nxt[lo] = nl; right_nxt[lo] = nr;
            for (int b = 0; b < BLOCKS - 1; b++)
              if (IW'(b) >= hi) begin
                left_nxt[b]  = left_r[b+1];
                right_nxt[b] = right_r[b+1];
              end
            held_nxt = held_r - 1'b1; recent_nxt = lo;
          end else begin
            recent_nxt = ai;
          end
        end else if (held_r >= CW'(BLOCKS)) begin
          for (int b = 0; b < BLOCKS - 1; b++) begin
            left_nxt[b] = left_r[b+1]; right_nxt[b] = right_r[b+1];
          end
          left_nxt[BLOCKS-1] = n; right_nxt[BLOCKS-1] = n1;
          recent_nxt = IW'(BLOCKS - 1); held_nxt = CW'(BLOCKS);
        end else begin
          left_nxt[held_r[IW-1:0]] = n; right_nxt[held_r[IW-1:0]] = n1;
          recent_nxt = held_r[IW-1:0]; held_nxt = held_r + 1'b1;
        end
      end
    end else if (cmd.do_ack) begin
      recent_nxt = '0;
      for (int b = 0; b < BLOCKS; b++)
        if (CW'(b) < held_r && left_r[b] > n) begin
          if (IW'(b) == recent_r) recent_nxt = kc[IW-1:0];
          left_nxt[kc[IW-1:0]]  = left_r[b];
          right_nxt[kc[IW-1:0]] = right_r[b];
          kc = kc + 1'b1;
        end
      held_nxt = kc;
      if (kc == '0) begin
        recent_nxt = '0; largest_nxt = '0;
      end
    end
  end

  // emission: table index for ordinal cur_r (first block, then rest in order)
  logic [CW-1:0] eidx;
  logic [IW-1:0] first_c;
  always_comb begin
    first_c = (CW'(recent_r) < held_r) ? recent_r : '0;
    if (cur_r == '0) eidx = CW'(first_r);
    else if (cur_r <= CW'(first_r)) eidx = cur_r - 1'b1;
    else eidx = cur_r;
  end
  assign sts.emit_done = (held_r == '0) || (cur_r + 1'b1 == held_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0; recent_r <= '0; largest_r <= '0; op_r <= '0; cur_r <= '0;
    end else begin
      if (cmd.load) begin
        op_r <= in_opcode; cur_r <= '0;
      end
      if (cmd.do_record || cmd.do_ack) begin
        held_r <= held_nxt; recent_r <= recent_nxt; largest_r <= largest_nxt;
      end
      if (cmd.emit_adv) cur_r <= cur_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      seq_r   <= SEQ_WIDTH'(in_seq);
      first_r <= first_c;
    end
    if (cmd.do_record || cmd.do_ack)
      for (int b = 0; b < BLOCKS; b++) begin
        left_r[b] <= left_nxt[b]; right_r[b] <= right_nxt[b];
      end
    if (cmd.emit_load) begin
      o_covered <= cmd.emit_blk ? 1'b0 : cov_nxt;
      o_count   <= 4'(cmd.emit_blk ? held_r : held_nxt);
      o_recent  <= 3'(cmd.emit_blk ? recent_r : recent_nxt);
      o_highest <= 32'(cmd.emit_blk ? largest_r : largest_nxt);
      if (cmd.emit_blk && held_r != '0) begin
        o_left   <= 32'(left_r[eidx[IW-1:0]]);
        o_right  <= 32'(right_r[eidx[IW-1:0]]);
        o_optlen <= 7'(OPT_BASE + 8 * held_r);
      end else begin
        o_left <= '0; o_right <= '0; o_optlen <= '0;
      end
      o_last <= cmd.emit_blk ? sts.emit_done : 1'b1;
    end
  end

endmodule

>>> rtl/core/sack_block_tracker_core.sv
// SACK block tracker: table of up to BLOCKS out-of-order ranges [left,right).
// Ops 0/1/3 give a single status result; op 2 gives one result per held block
// (one if the table is empty), each loaded after the previous one is accepted.
// One item at a time: input is not taken until the last result is accepted.
// Reset (rst_n low, synchronous) empties the table and clears recent/highest.
`timescale 1ns / 1ps
module sack_block_tracker_core #(
  parameter int unsigned BLOCKS    = 4,
  parameter int unsigned SEQ_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [1:0] opcode, [33:2] seq_number, rest zero
  output logic        out_tvalid,
  input  logic        out_tready,
  // [0] covered, [4:1] block_count, [7:5] recent_index, [39:8] highest_seen,
  // [71:40] start_seq, [103:72] end_seq, [110:104] option_length, rest zero
  output logic [111:0] out_tdata,
  output logic        out_tlast
);
  import sbt_pkg::*;

  sbt_cmd_t cmd;
  sbt_sts_t sts;
  logic     in_fire, out_fire;

  assign in_fire  = in_tvalid && in_tready;
  assign out_fire = out_tvalid && out_tready;

  logic        o_covered, o_last;
  logic [3:0]  o_count;
  logic [2:0]  o_recent;
  logic [31:0] o_highest, o_left, o_right;
  logic [6:0]  o_optlen;

  sbt_ctrl u_ctrl (
    .clk, .rst_n, .in_fire, .out_fire, .sts,
    .in_ready(in_tready), .out_valid(out_tvalid), .cmd
  );

  sbt_dp #(.BLOCKS(BLOCKS), .SEQ_WIDTH(SEQ_WIDTH)) u_dp (
    .clk, .rst_n, .cmd,
    .in_opcode(in_tdata[1:0]), .in_seq(in_tdata[33:2]), .sts,
    .o_covered, .o_count, .o_recent, .o_highest, .o_left, .o_right,
    .o_optlen, .o_last
  );

  assign out_tdata = {1'b0, o_optlen, o_right, o_left, o_highest, o_recent,
                      o_count, o_covered};
  assign out_tlast = o_last;

`ifndef SYNTHESIS
  // a result never appears while a new transaction is being taken
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid)) else $error("in/out overlap");
  // a non-last result must be followed by more results before new input
  a_more: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && !out_tlast) |=> !in_tready) else $error("early ready");
  // block count never exceeds the table size
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[4:1] <= 4'(BLOCKS))) else $error("count range");
`endif

endmodule
